// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the link quality checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LQWS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication
`define LQWS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// ===== src/lqws_pkg.sv =====
// ----------------------------------------------------------------------------
// lqws_pkg
// Types and constants shared by the link quality window statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package lqws_pkg;

   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] OP_REPLY   = 2'd0;
   localparam logic [1:0] OP_TIMEOUT = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;

   localparam logic [1:0] LINK_DOWN     = 2'd0;
   localparam logic [1:0] LINK_DEGRADED = 2'd1;
   localparam logic [1:0] LINK_UP       = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOSS_TMO    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOSS_DOWN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOSS_DEGR   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LAT_DEGR    = 3'd5;

   localparam logic [31:0] WINDOW_RESET    = 32'd60000;
   localparam logic [31:0] LOSS_TMO_RESET  = 32'd1000;
   localparam logic [31:0] PERIOD_RESET    = 32'd1000;
   localparam logic [6:0]  LOSS_DOWN_RESET = 7'd50;
   localparam logic [6:0]  LOSS_DEGR_RESET = 7'd5;
   localparam logic [15:0] LAT_DEGR_RESET  = 16'd200;

   localparam logic [6:0]  HELD_LOSS_RESET = 7'd100;
   localparam logic [6:0]  TOTAL_MAX       = 7'd127;
   localparam logic [6:0]  LOSS_SCALE      = 7'd100;

   // x / 1000 == (x * SPAN_RECIP) >> SPAN_SHIFT for every 32-bit x
   localparam logic [31:0] SPAN_RECIP = 32'd274877907;
   localparam int          SPAN_SHIFT = 38;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

endpackage

`default_nettype wire

// ===== src/lqws_div.sv =====
// ----------------------------------------------------------------------------
// lqws_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lqws_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire lqws_pkg::div_req_type            req,
   output logic                                  done,
   output logic [lqws_pkg::DIV_NUM_W-1:0]        quotient
);

   localparam int CNT_W = $clog2(lqws_pkg::DIV_NUM_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(lqws_pkg::DIV_NUM_W - 1);

   logic [lqws_pkg::DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [lqws_pkg::DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [lqws_pkg::DIV_DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [lqws_pkg::DIV_DEN_W:0]   shifted;
   logic                           ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[lqws_pkg::DIV_NUM_W-1]};
      ge      = shifted >= {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         quo_in = {quo_ff[lqws_pkg::DIV_NUM_W-2:0], ge};
         rem_in = ge ? lqws_pkg::DIV_DEN_W'(shifted - {1'b0, den_ff})
                     : shifted[lqws_pkg::DIV_DEN_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== src/lqws_sqrt.sv =====
// ----------------------------------------------------------------------------
// lqws_sqrt
// Iterative floor square root of a 32-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lqws_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] radicand,
   output logic             done,
   output logic [15:0]      root
);

   logic [31:0] v_ff, v_in;
   logic [31:0] res_ff, res_in;
   logic [31:0] bit_ff, bit_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] trial;

   always_comb begin
      trial   = res_ff + bit_ff;
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in   = v_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 4'hF) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         v_in    = radicand;
         res_in  = '0;
         bit_in  = 32'h4000_0000;
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      v_ff   <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[15:0];

endmodule

`default_nettype wire

// ===== src/link_quality_window_stats_core.sv =====
// Reply, timeout, early tick and unknown op: accepted in S_IDLE, ready again the next cycle.
// Evaluating tick: a slot-per-cycle scan, then at most three divisions and a square
//   root before rsp_valid; with no counted sample no division is made. req_stall
//   stays high until the result transfer.
// Reset (synchronous): a clearing pass over all SAMPLE_SLOTS slots zeroes the sample
//   memory; req_stall stays high meanwhile. Configuration writes are always taken.
// ----------------------------------------------------------------------------
// link_quality_window_stats_core
// Rolling window link statistics: mean, jitter, loss, span and link state.
// ----------------------------------------------------------------------------
`default_nettype none

module link_quality_window_stats_core #(
   parameter int SAMPLE_SLOTS = 120
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [lqws_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lqws_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [1:0]                         req_op,
   input  wire logic [31:0]                        req_now_ms,
   input  wire logic [15:0]                        req_reply_latency_ms,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_updated,
   output logic [15:0]                             rsp_mean_latency_ms,
   output logic [15:0]                             rsp_jitter,
   output logic [6:0]                              rsp_loss_percent,
   output logic [6:0]                              rsp_sample_total,
   output logic [15:0]                             rsp_span_seconds,
   output logic [1:0]                              rsp_link_state,
   output logic [31:0]                             rsp_update_time_ms
);

   localparam int IDX_W  = $clog2(SAMPLE_SLOTS);
   localparam int CNT_W  = $clog2(SAMPLE_SLOTS + 1);
   localparam int SUM_W  = 16 + IDX_W;
   localparam int SQ_W   = 32 + IDX_W;
   localparam int WORD_W = 49;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SAMPLE_SLOTS - 1);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_SCAN     = 4'd2;
   localparam logic [3:0] S_DRAIN    = 4'd3;
   localparam logic [3:0] S_DECIDE   = 4'd4;
   localparam logic [3:0] S_DIV_MEAN = 4'd5;
   localparam logic [3:0] S_DIV_MSQ  = 4'd6;
   localparam logic [3:0] S_SQRT     = 4'd7;
   localparam logic [3:0] S_DIV_LOSS = 4'd8;
   localparam logic [3:0] S_DIV_SPAN = 4'd9;
   localparam logic [3:0] S_CLASS    = 4'd10;
   localparam logic [3:0] S_OUT      = 4'd11;

   logic [WORD_W-1:0] mem [SAMPLE_SLOTS];
   logic [WORD_W-1:0] rd_data_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [WORD_W-1:0] mem_wdata;

   logic [3:0]        state_ff, state_in;
   logic [IDX_W-1:0]  clr_idx_ff, clr_idx_in;
   logic [IDX_W-1:0]  wslot_ff, wslot_in;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [31:0]       last_eval_ff, last_eval_in;
   logic [31:0]       now_ff, now_in;
   logic [31:0]       wstart_ff, wstart_in;
   logic [CNT_W-1:0]  rcv_ff, rcv_in;
   logic [CNT_W-1:0]  lost_ff, lost_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SQ_W-1:0]   sumsq_ff, sumsq_in;
   logic [31:0]       oldest_ff, oldest_in;
   logic [31:0]       newest_ff, newest_in;
   logic [15:0]       mean_ff, mean_in;
   logic [31:0]       mm_ff, mm_in;
   logic [15:0]       jit_ff, jit_in;
   logic [6:0]        loss_ff, loss_in;
   logic [15:0]       span_ff, span_in;

   logic [15:0]       h_mean_ff, h_mean_in;
   logic [15:0]       h_jit_ff, h_jit_in;
   logic [6:0]        h_loss_ff, h_loss_in;
   logic [6:0]        h_total_ff, h_total_in;
   logic [15:0]       h_span_ff, h_span_in;
   logic [1:0]        h_link_ff, h_link_in;
   logic [31:0]       h_time_ff, h_time_in;
   logic              upd_ff, upd_in;

   logic [31:0]       window_ff, loss_tmo_ff, period_ff;
   logic [6:0]        loss_down_ff, loss_degr_ff;
   logic [15:0]       lat_degr_ff;

   lqws_pkg::div_req_type                div_req;
   logic                                 div_done;
   logic [lqws_pkg::DIV_NUM_W-1:0]       div_q;
   logic                                 sqrt_start;
   logic [31:0]                          sqrt_in;
   logic                                 sqrt_done;
   logic [15:0]                          sqrt_root;

   logic              req_xfer;
   logic [31:0]       smp_time;
   logic              smp_rcvd;
   logic [15:0]       smp_lat;
   logic              smp_qual;
   logic [CNT_W-1:0]  total;
   logic [15:0]       total_ext;
   logic [31:0]       msq;
   logic [31:0]       span_diff;
   logic [63:0]       span_prod;

   lqws_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_q)
   );

   lqws_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_in),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign smp_time  = rd_data_ff[48:17];
   assign smp_rcvd  = rd_data_ff[16];
   assign smp_lat   = rd_data_ff[15:0];
   assign smp_qual  = (smp_time != 32'd0) && (smp_time >= wstart_ff);
   assign total     = rcv_ff + lost_ff;
   assign total_ext = 16'(total);
   assign msq       = div_q[31:0];
   assign span_diff = newest_ff - oldest_ff;
   assign span_prod = {32'd0, span_diff} * {32'd0, lqws_pkg::SPAN_RECIP};

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      wslot_in     = wslot_ff;
      scan_idx_in  = scan_idx_ff;
      rd_vld_in    = (state_ff == S_SCAN);
      last_eval_in = last_eval_ff;
      now_in       = now_ff;
      wstart_in    = wstart_ff;
      rcv_in       = rcv_ff;
      lost_in      = lost_ff;
      sum_in       = sum_ff;
      sumsq_in     = sumsq_ff;
      oldest_in    = oldest_ff;
      newest_in    = newest_ff;
      mean_in      = mean_ff;
      mm_in        = mm_ff;
      jit_in       = jit_ff;
      loss_in      = loss_ff;
      span_in      = span_ff;
      h_mean_in    = h_mean_ff;
      h_jit_in     = h_jit_ff;
      h_loss_in    = h_loss_ff;
      h_total_in   = h_total_ff;
      h_span_in    = h_span_ff;
      h_link_in    = h_link_ff;
      h_time_in    = h_time_ff;
      upd_in       = upd_ff;
      mem_we       = 1'b0;
      mem_waddr    = wslot_ff;
      mem_wdata    = '0;
      div_req      = '0;
      sqrt_start   = 1'b0;
      sqrt_in      = '0;

      if (rd_vld_ff && smp_qual) begin
         if (smp_time < oldest_ff) oldest_in = smp_time;
         if (smp_time > newest_ff) newest_in = smp_time;
         if (smp_rcvd) begin
            rcv_in   = rcv_ff + 1'b1;
            sum_in   = sum_ff + SUM_W'(smp_lat);
            sumsq_in = sumsq_ff + SQ_W'({16'd0, smp_lat} * {16'd0, smp_lat});
         end else if ((now_ff - smp_time) >= loss_tmo_ff) begin
            lost_in = lost_ff + 1'b1;
         end
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == LAST_SLOT) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_xfer) begin
               if (req_op inside {lqws_pkg::OP_REPLY, lqws_pkg::OP_TIMEOUT}) begin
                  mem_we   = 1'b1;
                  wslot_in = (wslot_ff == LAST_SLOT) ? '0 : wslot_ff + 1'b1;
                  if (req_op == lqws_pkg::OP_REPLY) begin
                     mem_wdata = {req_now_ms - 32'(req_reply_latency_ms), 1'b1,
                                  req_reply_latency_ms};
                  end else begin
                     mem_wdata = {req_now_ms, 1'b0, 16'd0};
                  end
               end else if (req_op == lqws_pkg::OP_TICK &&
                            (req_now_ms - last_eval_ff) >= period_ff) begin
                  last_eval_in = req_now_ms;
                  now_in       = req_now_ms;
                  wstart_in    = (req_now_ms > window_ff) ? req_now_ms - window_ff : '0;
                  rcv_in       = '0;
                  lost_in      = '0;
                  sum_in       = '0;
                  sumsq_in     = '0;
                  oldest_in    = req_now_ms;
                  newest_in    = '0;
                  scan_idx_in  = '0;
                  state_in     = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            scan_idx_in = scan_idx_ff + 1'b1;
            if (scan_idx_ff == LAST_SLOT) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            mean_in = '0;
            jit_in  = '0;
            span_in = '0;
            if (total == '0) begin
               upd_in   = 1'b0;
               state_in = S_OUT;
            end else if (rcv_ff != '0) begin
               div_req.start    = 1'b1;
               div_req.dividend = lqws_pkg::DIV_NUM_W'(sum_ff);
               div_req.divisor  = lqws_pkg::DIV_DEN_W'(rcv_ff);
               state_in         = S_DIV_MEAN;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = lqws_pkg::DIV_NUM_W'(lost_ff) *
                                  lqws_pkg::DIV_NUM_W'(lqws_pkg::LOSS_SCALE);
               div_req.divisor  = total_ext;
               state_in         = S_DIV_LOSS;
            end
         end
         S_DIV_MEAN: begin
            if (div_done) begin
               mean_in       = div_q[15:0];
               mm_in         = div_q[15:0] * div_q[15:0];
               div_req.start = 1'b1;
               if (rcv_ff > CNT_W'(1)) begin
                  div_req.dividend = lqws_pkg::DIV_NUM_W'(sumsq_ff);
                  div_req.divisor  = lqws_pkg::DIV_DEN_W'(rcv_ff);
                  state_in         = S_DIV_MSQ;
               end else begin
                  div_req.dividend = lqws_pkg::DIV_NUM_W'(lost_ff) *
                                     lqws_pkg::DIV_NUM_W'(lqws_pkg::LOSS_SCALE);
                  div_req.divisor  = total_ext;
                  state_in         = S_DIV_LOSS;
               end
            end
         end
         S_DIV_MSQ: begin
            if (div_done) begin
               sqrt_start = 1'b1;
               sqrt_in    = (msq >= mm_ff) ? msq - mm_ff : '0;
               state_in   = S_SQRT;
            end
         end
         S_SQRT: begin
            if (sqrt_done) begin
               jit_in           = sqrt_root;
               div_req.start    = 1'b1;
               div_req.dividend = lqws_pkg::DIV_NUM_W'(lost_ff) *
                                  lqws_pkg::DIV_NUM_W'(lqws_pkg::LOSS_SCALE);
               div_req.divisor  = total_ext;
               state_in         = S_DIV_LOSS;
            end
         end
         S_DIV_LOSS: begin
            if (div_done) begin
               loss_in  = div_q[6:0];
               state_in = S_DIV_SPAN;
            end
         end
         S_DIV_SPAN: begin
            if (newest_ff > oldest_ff) span_in = span_prod[lqws_pkg::SPAN_SHIFT +: 16];
            state_in = S_CLASS;
         end
         S_CLASS: begin
            h_mean_in  = mean_ff;
            h_jit_in   = jit_ff;
            h_loss_in  = loss_ff;
            h_total_in = (total_ext > 16'(lqws_pkg::TOTAL_MAX)) ? lqws_pkg::TOTAL_MAX
                                                                 : total_ext[6:0];
            h_span_in  = span_ff;
            h_time_in  = now_ff;
            if (loss_ff > loss_down_ff) begin
               h_link_in = lqws_pkg::LINK_DOWN;
            end else if (loss_ff > loss_degr_ff || mean_ff > lat_degr_ff) begin
               h_link_in = lqws_pkg::LINK_DEGRADED;
            end else begin
               h_link_in = lqws_pkg::LINK_UP;
            end
            upd_in   = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[scan_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         wslot_ff     <= '0;
         scan_idx_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         last_eval_ff <= '0;
         h_mean_ff    <= '0;
         h_jit_ff     <= '0;
         h_loss_ff    <= lqws_pkg::HELD_LOSS_RESET;
         h_total_ff   <= '0;
         h_span_ff    <= '0;
         h_link_ff    <= lqws_pkg::LINK_DOWN;
         h_time_ff    <= '0;
         upd_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         wslot_ff     <= wslot_in;
         scan_idx_ff  <= scan_idx_in;
         rd_vld_ff    <= rd_vld_in;
         last_eval_ff <= last_eval_in;
         h_mean_ff    <= h_mean_in;
         h_jit_ff     <= h_jit_in;
         h_loss_ff    <= h_loss_in;
         h_total_ff   <= h_total_in;
         h_span_ff    <= h_span_in;
         h_link_ff    <= h_link_in;
         h_time_ff    <= h_time_in;
         upd_ff       <= upd_in;
      end
      now_ff    <= now_in;
      wstart_ff <= wstart_in;
      rcv_ff    <= rcv_in;
      lost_ff   <= lost_in;
      sum_ff    <= sum_in;
      sumsq_ff  <= sumsq_in;
      oldest_ff <= oldest_in;
      newest_ff <= newest_in;
      mean_ff   <= mean_in;
      mm_ff     <= mm_in;
      jit_ff    <= jit_in;
      loss_ff   <= loss_in;
      span_ff   <= span_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= lqws_pkg::WINDOW_RESET;
         loss_tmo_ff  <= lqws_pkg::LOSS_TMO_RESET;
         period_ff    <= lqws_pkg::PERIOD_RESET;
         loss_down_ff <= lqws_pkg::LOSS_DOWN_RESET;
         loss_degr_ff <= lqws_pkg::LOSS_DEGR_RESET;
         lat_degr_ff  <= lqws_pkg::LAT_DEGR_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            lqws_pkg::CSR_WINDOW:    window_ff    <= csr_wdata;
            lqws_pkg::CSR_LOSS_TMO:  loss_tmo_ff  <= csr_wdata;
            lqws_pkg::CSR_PERIOD:    period_ff    <= csr_wdata;
            lqws_pkg::CSR_LOSS_DOWN: loss_down_ff <= csr_wdata[6:0];
            lqws_pkg::CSR_LOSS_DEGR: loss_degr_ff <= csr_wdata[6:0];
            lqws_pkg::CSR_LAT_DEGR:  lat_degr_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid           = (state_ff == S_OUT);
   assign rsp_updated         = upd_ff;
   assign rsp_mean_latency_ms = h_mean_ff;
   assign rsp_jitter          = h_jit_ff;
   assign rsp_loss_percent    = h_loss_ff;
   assign rsp_sample_total    = h_total_ff;
   assign rsp_span_seconds    = h_span_ff;
   assign rsp_link_state      = h_link_ff;
   assign rsp_update_time_ms  = h_time_ff;

endmodule

`default_nettype wire

// ===== src/lqws_checker.sv =====
// ----------------------------------------------------------------------------
// lqws_checker
// Port-level checks on the link quality statistics core, bound into the core.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lqws_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_updated,
   input wire logic [6:0] rsp_sample_total
);

   `LQWS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   `LQWS_ASSERT_IMP(a_busy_with_rsp, clock, reset, rsp_valid, req_stall)

   `LQWS_ASSERT_IMP(a_upd_has_samples, clock, reset, rsp_valid && rsp_updated,
                    rsp_sample_total != 7'd0)

   `LQWS_ASSERT_NXT(a_no_rsp_after_xfer, clock, reset,
                    req_valid && !req_stall, !rsp_valid)

endmodule

bind link_quality_window_stats_core lqws_checker u_lqws_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the link quality window statistics core. Probe
// replies, timeouts and ticks are sent through the request channel while a
// predictor keeps its own sample ring and held metrics; every evaluation
// result is compared field by field against the oldest predicted statistics.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   localparam int SLOTS          = 120;
   localparam int DRAIN_CYCLES   = 400;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [1:0] OP_UNKNOWN = 2'd3;

   typedef struct packed {
      logic        updated;
      logic [15:0] mean_latency;
      logic [15:0] jitter;
      logic [6:0]  loss;
      logic [6:0]  total;
      logic [15:0] span;
      logic [1:0]  link_state;
      logic [31:0] update_time;
   } link_stats_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [lqws_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [lqws_pkg::CSR_DATA_W-1:0] csr_wdata;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_op;
   logic [31:0] req_now_ms;
   logic [15:0] req_reply_latency_ms;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_updated;
   logic [15:0] rsp_mean_latency_ms;
   logic [15:0] rsp_jitter;
   logic [6:0]  rsp_loss_percent;
   logic [6:0]  rsp_sample_total;
   logic [15:0] rsp_span_seconds;
   logic [1:0]  rsp_link_state;
   logic [31:0] rsp_update_time_ms;

   link_quality_window_stats_core #(.SAMPLE_SLOTS(SLOTS)) i_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_now_ms(req_now_ms), .req_reply_latency_ms(req_reply_latency_ms),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_updated(rsp_updated),
      .rsp_mean_latency_ms(rsp_mean_latency_ms), .rsp_jitter(rsp_jitter),
      .rsp_loss_percent(rsp_loss_percent), .rsp_sample_total(rsp_sample_total),
      .rsp_span_seconds(rsp_span_seconds), .rsp_link_state(rsp_link_state),
      .rsp_update_time_ms(rsp_update_time_ms)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [31:0] ring_send[SLOTS];
   logic [15:0] ring_lat[SLOTS];
   bit          ring_rcv[SLOTS];
   int unsigned ring_slot;
   logic [31:0] last_eval;
   link_stats_type held;
   logic [31:0] cfg_window, cfg_loss_tmo, cfg_period;
   logic [6:0]  cfg_loss_down, cfg_loss_degr;
   logic [15:0] cfg_lat_degr;

   link_stats_type expected_stats_q[$];
   link_stats_type got_stats;
   int          fail_count = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          quiet_cycles = 0;
   bit          hold_off = 1'b0;
   logic [31:0] now_t;

   function automatic logic [31:0] floor_root(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = '0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res[31:0];
   endfunction

   function automatic void clear_predictor();
      foreach (ring_send[i]) begin
         ring_send[i] = '0;
         ring_lat[i] = '0;
         ring_rcv[i] = 1'b0;
      end
      ring_slot = 0;
      last_eval = '0;
      held = '0;
      held.loss = lqws_pkg::HELD_LOSS_RESET;
      held.link_state = lqws_pkg::LINK_DOWN;
      cfg_window = lqws_pkg::WINDOW_RESET;
      cfg_loss_tmo = lqws_pkg::LOSS_TMO_RESET;
      cfg_period = lqws_pkg::PERIOD_RESET;
      cfg_loss_down = lqws_pkg::LOSS_DOWN_RESET;
      cfg_loss_degr = lqws_pkg::LOSS_DEGR_RESET;
      cfg_lat_degr = lqws_pkg::LAT_DEGR_RESET;
   endfunction

   function automatic void store_sample(logic [31:0] send, logic [15:0] lat, bit rcv);
      ring_send[ring_slot] = send;
      ring_lat[ring_slot] = lat;
      ring_rcv[ring_slot] = rcv;
      ring_slot = (ring_slot + 1) % SLOTS;
   endfunction

   function automatic void scan_window(logic [31:0] now);
      logic [31:0] wstart, oldest, newest, t;
      logic [63:0] sum, sumsq, m, msq, spread;
      int unsigned rcv, lost, total;
      link_stats_type r;
      wstart = (now > cfg_window) ? now - cfg_window : 32'd0;
      oldest = now;
      newest = '0;
      sum = '0;
      sumsq = '0;
      rcv = 0;
      lost = 0;
      for (int i = 0; i < SLOTS; i++) begin
         t = ring_send[i];
         if (t != 0 && t >= wstart) begin
            if (t < oldest) oldest = t;
            if (t > newest) newest = t;
            if (ring_rcv[i]) begin
               rcv++;
               sum += 64'(ring_lat[i]);
               sumsq += 64'(ring_lat[i]) * 64'(ring_lat[i]);
            end else if (32'(now - t) >= cfg_loss_tmo) begin
               lost++;
            end
         end
      end
      total = rcv + lost;
      if (total == 0) begin
         r = held;
         r.updated = 1'b0;
         expected_stats_q.push_back(r);
         return;
      end
      r = '0;
      r.updated = 1'b1;
      if (rcv > 0) r.mean_latency = 16'(sum / rcv);
      if (rcv > 1) begin
         m = sum / rcv;
         msq = sumsq / rcv;
         spread = (msq >= m * m) ? msq - m * m : 64'd0;
         r.jitter = 16'(floor_root(spread));
      end
      r.loss = 7'((lost * 100) / total);
      r.total = (total > 127) ? lqws_pkg::TOTAL_MAX : 7'(total);
      r.span = (newest > oldest) ? 16'((newest - oldest) / 1000) : 16'd0;
      if (r.loss > cfg_loss_down) r.link_state = lqws_pkg::LINK_DOWN;
      else if (r.loss > cfg_loss_degr || r.mean_latency > cfg_lat_degr)
         r.link_state = lqws_pkg::LINK_DEGRADED;
      else r.link_state = lqws_pkg::LINK_UP;
      r.update_time = now;
      held = r;
      expected_stats_q.push_back(r);
   endfunction

   function automatic void predict_event(logic [1:0] op, logic [31:0] now,
                                         logic [15:0] lat);
      if (op == lqws_pkg::OP_REPLY) begin
         store_sample(32'(now - {16'd0, lat}), lat, 1'b1);
      end else if (op == lqws_pkg::OP_TIMEOUT) begin
         store_sample(now, 16'd0, 1'b0);
      end else if (op == lqws_pkg::OP_TICK && 32'(now - last_eval) >= cfg_period) begin
         last_eval = now;
         scan_window(now);
      end
   endfunction

   task automatic send_event(logic [1:0] op, logic [31:0] now, logic [15:0] lat);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_now_ms <= now;
      req_reply_latency_ms <= lat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_event(op, now, lat);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_stats_q.size() != 0) @(posedge clock);
      hold_off = 1'b1;
      repeat (DRAIN_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   endtask

   task automatic write_reg(logic [lqws_pkg::CSR_IDX_W-1:0] idx, logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         lqws_pkg::CSR_WINDOW:    cfg_window = data;
         lqws_pkg::CSR_LOSS_TMO:  cfg_loss_tmo = data;
         lqws_pkg::CSR_PERIOD:    cfg_period = data;
         lqws_pkg::CSR_LOSS_DOWN: cfg_loss_down = data[6:0];
         lqws_pkg::CSR_LOSS_DEGR: cfg_loss_degr = data[6:0];
         lqws_pkg::CSR_LAT_DEGR:  cfg_lat_degr = data[15:0];
         default: ;
      endcase
   endtask

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // random probe traffic: time mostly creeps forward, occasionally jumps
   task automatic random_burst(int count);
      int pick;
      logic [1:0] op;
      logic [15:0] lat;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 2) now_t = $urandom;
         else now_t = now_t + $urandom_range(1, 300);
         pick = $urandom_range(99);
         if (pick < 45) op = lqws_pkg::OP_REPLY;
         else if (pick < 70) op = lqws_pkg::OP_TIMEOUT;
         else if (pick < 96) op = lqws_pkg::OP_TICK;
         else op = OP_UNKNOWN;
         lat = ($urandom_range(99) < 85) ? 16'($urandom_range(0, 400)) : 16'($urandom);
         send_event(op, now_t, lat);
      end
   endtask

   task automatic test_basic_events();
      send_event(lqws_pkg::OP_TICK, 32'd500, 16'd0);
      send_event(lqws_pkg::OP_TICK, 32'd1000, 16'd0);
      send_event(lqws_pkg::OP_REPLY, 32'd150, 16'd150);
      send_event(lqws_pkg::OP_REPLY, 32'd2000, 16'd0);
      send_event(lqws_pkg::OP_REPLY, 32'd2100, 16'hFFFF);
      send_event(lqws_pkg::OP_TIMEOUT, 32'd2200, 16'hFFFF);
      send_event(OP_UNKNOWN, 32'd2300, 16'd5);
      send_event(lqws_pkg::OP_TICK, 32'd2500, 16'd0);
      send_event(lqws_pkg::OP_TIMEOUT, 32'd0, 16'd0);
      send_event(lqws_pkg::OP_REPLY, 32'd3000, 16'd300);
      send_event(lqws_pkg::OP_REPLY, 32'd3100, 16'd20);
      send_event(lqws_pkg::OP_TICK, 32'd4000, 16'd0);
      send_event(lqws_pkg::OP_TICK, 32'd4500, 16'd0);
      send_event(lqws_pkg::OP_TICK, 32'hFFFF_FFF0, 16'd0);
      send_event(lqws_pkg::OP_REPLY, 32'hFFFF_FFF8, 16'd5);
      send_event(lqws_pkg::OP_TIMEOUT, 32'hFFFF_FFFF, 16'd0);
      send_event(lqws_pkg::OP_TICK, 32'hFFFF_FFFF, 16'd0);
      send_event(lqws_pkg::OP_TICK, 32'd2000, 16'd0);
      settle();
   endtask

   task automatic test_config_extremes();
      write_reg(lqws_pkg::CSR_WINDOW, 32'd1);
      write_reg(lqws_pkg::CSR_LOSS_TMO, 32'd0);
      write_reg(lqws_pkg::CSR_PERIOD, 32'd0);
      write_reg(lqws_pkg::CSR_LOSS_DOWN, 32'd0);
      write_reg(lqws_pkg::CSR_LOSS_DEGR, 32'd0);
      write_reg(lqws_pkg::CSR_LAT_DEGR, 32'd0);
      now_t = 32'd10000;
      random_burst(20);
      settle();
      write_reg(lqws_pkg::CSR_WINDOW, 32'hFFFF_FFFF);
      write_reg(lqws_pkg::CSR_LOSS_TMO, 32'hFFFF_FFFF);
      write_reg(lqws_pkg::CSR_PERIOD, 32'd0);
      write_reg(lqws_pkg::CSR_LOSS_DOWN, 32'd100);
      write_reg(lqws_pkg::CSR_LOSS_DEGR, 32'd127);
      write_reg(lqws_pkg::CSR_LAT_DEGR, 32'd65535);
      write_reg(3'd6, $urandom);
      write_reg(3'd7, $urandom);
      random_burst(20);
      settle();
      write_reg(lqws_pkg::CSR_PERIOD, 32'hFFFF_FFFF);
      random_burst(10);
      settle();
   endtask

   task automatic test_random_phase(int idle, int stall, int count);
      int w;
      w = $urandom_range(3);
      write_reg(lqws_pkg::CSR_WINDOW, (w == 0) ? 32'd1000 : (w == 1) ? 32'd5000 :
                                      (w == 2) ? 32'd60000 : $urandom);
      write_reg(lqws_pkg::CSR_LOSS_TMO, 32'($urandom_range(0, 3000)));
      write_reg(lqws_pkg::CSR_PERIOD, 32'($urandom_range(0, 2000)));
      write_reg(lqws_pkg::CSR_LOSS_DOWN, 32'($urandom_range(0, 100)));
      write_reg(lqws_pkg::CSR_LOSS_DEGR, 32'($urandom_range(0, 100)));
      write_reg(lqws_pkg::CSR_LAT_DEGR, ($urandom_range(3) == 0) ? 32'd65535 :
                                        32'($urandom_range(0, 400)));
      idle_pct = idle;
      stall_pct = stall;
      random_burst(count);
      settle();
      idle_pct = 0;
      stall_pct = 0;
   endtask

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_stats_q.size() == 0) begin
            $error("result transfer with no prediction pending");
            fail_count++;
         end else begin
            got_stats = expected_stats_q.pop_front();
            check_field("updated", got_stats.updated, rsp_updated);
            check_field("mean_latency_ms", got_stats.mean_latency, rsp_mean_latency_ms);
            check_field("jitter", got_stats.jitter, rsp_jitter);
            check_field("loss_percent", got_stats.loss, rsp_loss_percent);
            check_field("sample_total", got_stats.total, rsp_sample_total);
            check_field("span_seconds", got_stats.span, rsp_span_seconds);
            check_field("link_state", got_stats.link_state, rsp_link_state);
            check_field("update_time_ms", got_stats.update_time, rsp_update_time_ms);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || hold_off || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("link_quality_window_stats_core test failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_op = lqws_pkg::OP_REPLY;
      req_now_ms = '0;
      req_reply_latency_ms = '0;
      rsp_stall = 1'b0;
      clear_predictor();
      now_t = 32'd5000;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_basic_events();
      test_config_extremes();
      test_random_phase(0, 0, 400);
      test_random_phase(52, 0, 400);
      test_random_phase(0, 52, 400);
      test_random_phase(24, 24, 400);
      settle();
      if (fail_count == 0 && expected_stats_q.size() == 0)
         $display("link_quality_window_stats_core test passed");
      else
         $display("link_quality_window_stats_core test failed");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+src
src/lqws_pkg.sv
src/lqws_div.sv
src/lqws_sqrt.sv
src/link_quality_window_stats_core.sv
src/lqws_checker.sv
tb/tb_top.sv
